@@ rtl/pie_pkg.sv @@
// Package: shared constants and types for the parenthesized infix evaluator.
`timescale 1ns / 1ps
package pie_pkg;
  localparam int NestDepth = 16;
  localparam int LvlW = $clog2(NestDepth + 1);
  localparam int IdxW = (NestDepth > 1) ? $clog2(NestDepth) : 1;

  typedef enum logic [2:0] {
    StOk = 3'd0, StSyntax = 3'd1, StDivZero = 3'd2, StIncomplete = 3'd3, StOverflow = 3'd4
  } status_e;

  typedef enum logic [1:0] {OpAdd = 2'd0, OpSub = 2'd1, OpMul = 2'd2, OpDiv = 2'd3} op_e;

  typedef enum logic [1:0] {
    PhLeft = 2'd0, PhOper = 2'd1, PhRight = 2'd2, PhClose = 2'd3
  } phase_e;

  typedef struct packed {
    logic [31:0] left;
    op_e         op;
    phase_e      phase;
  } frame_t;

  typedef struct packed {
    logic        start;
    op_e         op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic        dz;
    logic [31:0] res;
  } alu_rsp_t;
endpackage

@@ rtl/pie_frame_ram.sv @@
// Frame stack memory: one write port, one registered read port.
`timescale 1ns / 1ps
module pie_frame_ram import pie_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [IdxW-1:0]    waddr_i,
  input  frame_t             wdata_i,
  input  logic [IdxW-1:0]    raddr_i,
  output frame_t             rdata_o
);
  frame_t mem [NestDepth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ rtl/pie_alu.sv @@
// Multicycle arithmetic unit: add/sub/mul straight into the response register, restoring divide one bit a cycle.
`timescale 1ns / 1ps
module pie_alu import pie_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);
  logic        busy_q, busy_d, neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d, rem_q, rem_d, div_q, div_d;
  alu_rsp_t    rsp_q, rsp_d;
  logic [32:0] trial;
  logic [31:0] rem_sh;

  always_comb begin
    busy_d = busy_q; cnt_d = cnt_q; quo_d = quo_q; rem_d = rem_q; div_d = div_q;
    neg_d = neg_q;
    rsp_d = '0;
    rem_sh = {rem_q[30:0], quo_q[31]};
    trial = {1'b0, rem_sh} - {1'b0, div_q};
    if (req_i.start) begin
      case (req_i.op)
        OpAdd: begin rsp_d.done = 1'b1; rsp_d.res = req_i.a + req_i.b; end
        OpSub: begin rsp_d.done = 1'b1; rsp_d.res = req_i.a - req_i.b; end
        OpMul: begin rsp_d.done = 1'b1; rsp_d.res = req_i.a * req_i.b; end
        default: begin
          if (req_i.b == '0) begin
            rsp_d.done = 1'b1; rsp_d.dz = 1'b1;
          end else begin
            busy_d = 1'b1; cnt_d = 6'd32; rem_d = '0;
            quo_d = req_i.a[31] ? 32'd0 - req_i.a : req_i.a;
            div_d = req_i.b[31] ? 32'd0 - req_i.b : req_i.b;
            neg_d = req_i.a[31] ^ req_i.b[31];
          end
        end
      endcase
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0]; quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh; quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; rsp_d.done = 1'b1;
        rsp_d.res = neg_q ? 32'd0 - quo_d : quo_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; rsp_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; rsp_q <= rsp_d;
    end
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; div_q <= div_d; neg_q <= neg_d;
  end
  assign rsp_o = rsp_q;
endmodule

@@ rtl/paren_infix_evaluator.sv @@
// Top level: byte-serial fully parenthesized infix evaluator.
//
// Input channel s_axis_*: one text byte per beat. Digits build a decimal
// number, + - * / ( ) are tokens, newline or zero ends the line, other bytes
// are ignored. Output channel m_axis_*: one beat per finished expression or
// error, carrying the 32-bit wrapped value and a status code.
// Open frames sit in a 16-entry synchronous RAM. A digit is accepted, then
// accumulated; any other byte is accepted, the top frame is read, then it is
// updated. Ending a number adds a pass that hands the operand to the top
// frame, and closing a frame with ')' re-reads the parent frame. Applying
// + - * goes through the ALU; a divide runs the one-bit-a-cycle restoring
// divider. A finished result is staged and then waits in the
// output register; intake goes on until the next result is staged, then
// stalls while m_axis_tready is low.
// Reset clears the level count, the number builder and the output register;
// the frame RAM is not cleared: frame 0 reads as fresh until first written,
// and every other frame is written when it is opened.
`timescale 1ns / 1ps
module paren_infix_evaluator import pie_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [31:0] value, [34:32] status, rest zero
);
  typedef enum logic [2:0] {SIdle, SRead, SExec, SAlu, SWait, SPop} state_e;

  state_e          state_q;
  logic [7:0]      ch_q;
  logic [31:0]     acc_q, opnd_q;
  logic            numact_q, numpend_q, chpend_q;
  logic [LvlW-1:0] lvl_q;
  logic            fresh_q;
  logic            ovld_q;
  logic [31:0]     oval_q;
  status_e         ost_q;
  logic [31:0]     rval_q;
  status_e         rstat_q;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  frame_t          wdata, top;
  alu_req_t        areq;
  alu_rsp_t        arsp;

  logic is_dig, is_eol, is_tok;
  logic [IdxW-1:0] tidx;
  logic [LvlW-1:0] lvl_eff;
  assign is_dig = (ch_q >= "0") && (ch_q <= "9");
  assign is_eol = (ch_q == 8'd0) || (ch_q == 8'h0A);
  assign is_tok = (ch_q == "+") || (ch_q == "-") || (ch_q == "*") || (ch_q == "/") ||
                  (ch_q == "(") || (ch_q == ")");
  assign tidx   = IdxW'(lvl_q - LvlW'(1));
  // level once frame 0 is open
  assign lvl_eff = (lvl_q == '0) ? LvlW'(1) : lvl_q;

  pie_frame_ram u_ram (.clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
                       .raddr_i(raddr), .rdata_o(top));
  pie_alu u_alu (.clk_i, .rst_ni, .req_i(areq), .rsp_o(arsp));

  assign s_axis_tready_o = (state_q == SIdle);
  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = {5'd0, ost_q, oval_q};
  assign raddr = tidx;

  // effective top frame: a fresh frame 0 when idle or not yet written
  frame_t cur;
  always_comb begin
    cur = top;
    if (lvl_q == '0 || (lvl_q == LvlW'(1) && fresh_q)) cur.phase = PhLeft;
  end

  always_comb begin
    we = 1'b0; waddr = tidx; wdata = cur; areq = '0;
    if (state_q == SExec && numpend_q && cur.phase == PhLeft && lvl_q != '0) begin
      we = 1'b1; wdata.left = opnd_q; wdata.phase = PhOper;
    end else if (state_q == SExec && numpend_q && cur.phase == PhRight) begin
      areq.start = 1'b1; areq.op = cur.op; areq.a = cur.left; areq.b = opnd_q;
    end else if (state_q == SExec && !numpend_q && chpend_q && is_tok) begin
      if (ch_q == "(") begin
        if ((cur.phase == PhLeft || cur.phase == PhRight) &&
            lvl_eff < LvlW'(NestDepth)) begin
          we = 1'b1; waddr = IdxW'(lvl_eff); wdata.phase = PhLeft;
        end
      end else if (ch_q != ")" && cur.phase == PhOper) begin
        we = 1'b1;
        wdata.phase = PhRight;
        case (ch_q)
          "+":     wdata.op = OpAdd;
          "-":     wdata.op = OpSub;
          "*":     wdata.op = OpMul;
          default: wdata.op = OpDiv;
        endcase
      end
    end else if (state_q == SAlu && arsp.done && !arsp.dz && tidx != '0) begin
      we = 1'b1; wdata.left = arsp.res; wdata.phase = PhClose;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) ch_q <= s_axis_tdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; acc_q <= '0; numact_q <= 1'b0; numpend_q <= 1'b0;
      chpend_q <= 1'b0; lvl_q <= '0; ovld_q <= 1'b0; oval_q <= '0; ost_q <= StOk;
      opnd_q <= '0; fresh_q <= 1'b1; rval_q <= '0; rstat_q <= StOk;
    end else begin
      if (ovld_q && m_axis_tready_i) ovld_q <= 1'b0;
      if (we && waddr == '0) fresh_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (s_axis_tvalid_i) begin
            state_q <= SRead;
          end
        end
        SRead: begin
          state_q <= SExec; chpend_q <= 1'b1; numpend_q <= 1'b0;
          if (is_dig) begin
            chpend_q <= 1'b0; state_q <= SIdle;
            if (lvl_q == '0) lvl_q <= LvlW'(1);
            acc_q <= numact_q ? acc_q * 32'd10 + {28'd0, ch_q[3:0]} : {28'd0, ch_q[3:0]};
            numact_q <= 1'b1;
          end else if (numact_q) begin
            numact_q <= 1'b0; numpend_q <= 1'b1; opnd_q <= acc_q;
          end
        end
        SExec: begin
          state_q <= SIdle;
          if (numpend_q) begin
            // hand an operand to the top frame
            numpend_q <= 1'b0;
            if (cur.phase == PhLeft) begin
              state_q <= chpend_q ? SRead : SIdle;
            end else if (cur.phase == PhRight) begin
              state_q <= SAlu;
            end else begin
              state_q <= SWait; rval_q <= '0; rstat_q <= StSyntax; chpend_q <= 1'b0;
            end
          end else if (chpend_q) begin
            chpend_q <= 1'b0;
            if (is_eol) begin
              if (lvl_q != '0) begin
                state_q <= SWait; rval_q <= '0; rstat_q <= StIncomplete;
              end
            end else if (is_tok) begin
              if (lvl_q == '0) lvl_q <= LvlW'(1);
              if (ch_q == "(") begin
                if (cur.phase != PhLeft && cur.phase != PhRight) begin
                  state_q <= SWait; rval_q <= '0; rstat_q <= StSyntax;
                end else if (lvl_eff >= LvlW'(NestDepth)) begin
                  state_q <= SWait; rval_q <= '0; rstat_q <= StOverflow;
                end else begin
                  lvl_q <= lvl_eff + LvlW'(1);
                end
              end else if (ch_q == ")") begin
                if (cur.phase != PhClose || lvl_q <= LvlW'(1)) begin
                  state_q <= SWait; rval_q <= '0; rstat_q <= StSyntax;
                end else begin
                  // pop, then read the parent before delivering the value
                  lvl_q <= lvl_q - LvlW'(1); opnd_q <= cur.left;
                  numpend_q <= 1'b1; state_q <= SPop;
                end
              end else if (cur.phase != PhOper) begin
                state_q <= SWait; rval_q <= '0; rstat_q <= StSyntax;
              end
            end
          end
        end
        SPop: state_q <= SExec;
        SAlu: begin
          if (arsp.done) begin
            if (arsp.dz) begin
              state_q <= SWait; rval_q <= '0; rstat_q <= StDivZero; chpend_q <= 1'b0;
            end else if (tidx == '0) begin
              state_q <= SWait; rval_q <= arsp.res; rstat_q <= StOk; chpend_q <= 1'b0;
            end else begin
              state_q <= chpend_q ? SRead : SIdle;
            end
          end
        end
        SWait: begin
          // publish once the output register is free
          if (!ovld_q || m_axis_tready_i) begin
            ovld_q <= 1'b1; oval_q <= rval_q; ost_q <= rstat_q;
            state_q <= SIdle; lvl_q <= '0; fresh_q <= 1'b1;
            numact_q <= 1'b0; acc_q <= '0;
          end
        end
        default: state_q <= SIdle;
      endcase
      // re-reading after an operand: skip the number step on the second pass
      if (state_q == SExec && numpend_q && cur.phase == PhLeft) numact_q <= 1'b0;
    end
  end

  status_e ost_prev;
  assign ost_prev = ost_q;
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> state_q == SIdle) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && !m_axis_tready_i) |=> ovld_q && $stable(oval_q))
    else $error("output changed under stall");
  a_lvl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LvlW'(NestDepth)) else $error("level beyond depth");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && ost_prev != StOk) |-> oval_q == '0) else $error("error with value");
endmodule
